>>> sv/mst_pkg.sv
// Shared token codes, error causes and tag helpers for the MessagePack tokenizer.
package mst_pkg;

    typedef enum logic [3:0] {
        KIND_NIL    = 4'd0,
        KIND_FALSE  = 4'd1,
        KIND_TRUE   = 4'd2,
        KIND_UINT   = 4'd3,
        KIND_SINT   = 4'd4,
        KIND_F32    = 4'd5,
        KIND_F64    = 4'd6,
        KIND_STRHDR = 4'd7,
        KIND_STRBYT = 4'd8,
        KIND_ARRAY  = 4'd9,
        KIND_MAP    = 4'd10,
        KIND_ERROR  = 4'd11
    } t_kind;

    localparam logic [63:0] CAUSE_TRUNC    = 64'd1;
    localparam logic [63:0] CAUSE_BAD_TAG  = 64'd2;
    localparam logic [63:0] CAUSE_OVERFLOW = 64'd3;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [4:0]  level;
        logic        done;
        logic [31:0] used;
        logic        last;
    } t_tok;

    // Number of payload bytes that follow a header tag (0: tag stands alone).
    function automatic logic [3:0] payload_size(input logic [7:0] t);
        logic [3:0] n;
        n = 4'd0;
        case (t)
            8'hc4, 8'hcc, 8'hd0, 8'hd9: n = 4'd1;
            8'hc5, 8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde: n = 4'd2;
            8'hc6, 8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: n = 4'd4;
            8'hcb, 8'hcf, 8'hd3: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

>>> sv/msgpack_stream_tokenizer.sv
// Streaming MessagePack tokenizer: byte in, tokens out through a three-entry queue.
//
// Takes one encoded MessagePack byte per beat (with a flag on the buffer's last byte)
// and emits tokens for one top-level object: scalars, string/binary headers and their
// bytes, array/map headers with counts. A byte accepted at an edge is decoded in the
// same cycle against the parse state and its tokens (at most two: the byte's own token
// and a truncation error) are queued; the queue head is the output. One byte is taken
// every cycle as long as the queue keeps room for two tokens, so the sustained rate is
// one byte per cycle; a byte yielding two tokens needs two output beats to drain.
// Nesting is held in MAX_DEPTH registered levels of remaining-element counts; closing
// an element pops every finished level at once through a priority search over the
// levels. After the object completes or an error token is sent, input bytes are
// accepted and dropped until reset.
module msgpack_stream_tokenizer #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_end_of_buffer,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mst_pkg::t_kind       o_token_kind,
    output logic [63:0]          o_token_value,
    output logic [4:0]           o_nest_level,
    output logic                 o_object_done,
    output logic [31:0]          o_bytes_used,
    output logic                 o_last_of_run
);
    import mst_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    typedef enum logic [1:0] {PH_TAG, PH_HEAD, PH_BODY} t_phase;
    typedef enum logic [1:0] {ACT_SCALAR, ACT_CONT, ACT_STR, ACT_ERR} t_act;

    // parse state
    logic [32:0]    r_rem [MAX_DEPTH];
    logic [DW-1:0]  r_depth;
    t_phase         r_phase;
    logic [7:0]     r_tag;
    logic [63:0]    r_shift;
    logic [31:0]    r_left;
    logic [31:0]    r_count;
    logic           r_fin;
    logic           r_err;

    // output queue
    t_tok           r_q [3];
    logic [1:0]     r_rd, r_wr, r_cnt;

    logic in_acc, out_acc;
    assign out_acc    = o_out_valid && i_out_ready;
    assign o_in_ready = (r_cnt - {1'b0, out_acc}) <= 2'd1;
    assign in_acc     = i_in_valid && o_in_ready;

    // --- close: find highest level that stays open after decrement
    logic [DW-1:0] cl_top;
    logic          cl_found;
    always_comb begin
        cl_top   = '0;
        cl_found = 1'b0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (DW'(i) < r_depth && r_rem[i] != 33'd1) begin
                cl_top   = DW'(i);
                cl_found = 1'b1;
            end
        end
    end

    // --- tag delivery
    logic [7:0]  d_tag;
    logic [63:0] d_val;
    t_act        d_act;
    t_kind       d_kind;
    logic [63:0] d_out;
    logic        d_map;

    // held tag once its payload is in, else the byte itself
    assign d_tag = (r_phase == PH_HEAD) ? r_tag : i_in_byte;
    assign d_val = {r_shift[55:0], i_in_byte};

    always_comb begin
        d_act  = ACT_ERR;
        d_kind = KIND_ERROR;
        d_out  = CAUSE_BAD_TAG;
        d_map  = 1'b0;
        if (d_tag <= 8'h7f) begin
            d_act = ACT_SCALAR; d_kind = KIND_UINT; d_out = {56'd0, d_tag};
        end else if (d_tag <= 8'h8f) begin
            d_act = ACT_CONT; d_kind = KIND_MAP; d_map = 1'b1;
            d_out = {60'd0, d_tag[3:0]};
        end else if (d_tag <= 8'h9f) begin
            d_act = ACT_CONT; d_kind = KIND_ARRAY; d_out = {60'd0, d_tag[3:0]};
        end else if (d_tag <= 8'hbf) begin
            d_act = ACT_STR; d_kind = KIND_STRHDR; d_out = {59'd0, d_tag[4:0]};
        end else if (d_tag >= 8'he0) begin
            d_act = ACT_SCALAR; d_kind = KIND_SINT; d_out = {56'hFFFFFFFFFFFFFF, d_tag};
        end else begin
            case (d_tag)
                8'hc0: begin d_act = ACT_SCALAR; d_kind = KIND_NIL;   d_out = 64'd0; end
                8'hc2: begin d_act = ACT_SCALAR; d_kind = KIND_FALSE; d_out = 64'd0; end
                8'hc3: begin d_act = ACT_SCALAR; d_kind = KIND_TRUE;  d_out = 64'd1; end
                8'hc4, 8'hc5, 8'hc6, 8'hd9, 8'hda, 8'hdb: begin
                    d_act = ACT_STR; d_kind = KIND_STRHDR; d_out = d_val;
                end
                8'hca: begin d_act = ACT_SCALAR; d_kind = KIND_F32; d_out = d_val; end
                8'hcb: begin d_act = ACT_SCALAR; d_kind = KIND_F64; d_out = d_val; end
                8'hcc, 8'hcd, 8'hce, 8'hcf: begin
                    d_act = ACT_SCALAR; d_kind = KIND_UINT; d_out = d_val;
                end
                8'hd0: begin
                    d_act = ACT_SCALAR; d_kind = KIND_SINT;
                    d_out = {{56{d_val[7]}}, d_val[7:0]};
                end
                8'hd1: begin
                    d_act = ACT_SCALAR; d_kind = KIND_SINT;
                    d_out = {{48{d_val[15]}}, d_val[15:0]};
                end
                8'hd2: begin
                    d_act = ACT_SCALAR; d_kind = KIND_SINT;
                    d_out = {{32{d_val[31]}}, d_val[31:0]};
                end
                8'hd3: begin d_act = ACT_SCALAR; d_kind = KIND_SINT; d_out = d_val; end
                8'hdc, 8'hdd: begin d_act = ACT_CONT; d_kind = KIND_ARRAY; d_out = d_val; end
                8'hde, 8'hdf: begin
                    d_act = ACT_CONT; d_kind = KIND_MAP; d_map = 1'b1; d_out = d_val;
                end
                default: begin d_act = ACT_ERR; d_kind = KIND_ERROR; d_out = CAUSE_BAD_TAG; end
            endcase
        end
    end

    // --- per-byte decode
    logic [31:0]   n_count;
    t_phase        n_phase;
    logic [7:0]    n_tag;
    logic [63:0]   n_shift;
    logic [31:0]   n_left;
    logic          n_err, n_fin;
    logic          do_close, do_push, do_deliver;
    logic [32:0]   push_val;
    logic [DW-1:0] n_depth;
    logic          m_vld, e_vld;
    t_tok          m_tok, e_tok;
    logic [3:0]    psz;

    always_comb begin
        n_count    = (r_count != 32'hFFFFFFFF) ? r_count + 32'd1 : r_count;
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_shift    = r_shift;
        n_left     = r_left;
        n_err      = r_err;
        n_fin      = r_fin;
        do_close   = 1'b0;
        do_push    = 1'b0;
        do_deliver = 1'b0;
        push_val   = '0;
        m_vld      = 1'b0;
        psz        = payload_size(i_in_byte);
        m_tok      = '{kind: KIND_NIL, value: 64'd0, level: 5'(r_depth), done: 1'b0,
                       used: n_count, last: 1'b0};

        unique case (r_phase)
            PH_HEAD: begin
                n_shift = {r_shift[55:0], i_in_byte};
                n_left  = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    n_phase    = PH_TAG;
                    do_deliver = 1'b1;
                end
            end
            PH_BODY: begin
                n_left      = r_left - 32'd1;
                m_vld       = 1'b1;
                m_tok.kind  = KIND_STRBYT;
                m_tok.value = {56'd0, i_in_byte};
                if (n_left == 32'd0) begin
                    n_phase  = PH_TAG;
                    do_close = 1'b1;
                end
            end
            default: begin
                n_tag = i_in_byte;
                if (psz != 4'd0) begin
                    n_shift = 64'd0;
                    n_left  = {28'd0, psz};
                    n_phase = PH_HEAD;
                end else begin
                    do_deliver = 1'b1;
                end
            end
        endcase

        if (do_deliver) begin
            m_vld       = 1'b1;
            m_tok.kind  = d_kind;
            m_tok.value = d_out;
            case (d_act)
                ACT_SCALAR: do_close = 1'b1;
                ACT_CONT: begin
                    if (d_out == 64'd0) begin
                        do_close = 1'b1;
                    end else if (r_depth >= DEPTH_MAX) begin
                        m_tok.kind  = KIND_ERROR;
                        m_tok.value = CAUSE_OVERFLOW;
                        n_err       = 1'b1;
                        n_phase     = PH_TAG;
                    end else begin
                        do_push  = 1'b1;
                        push_val = d_map ? {d_out[31:0], 1'b0} : {1'b0, d_out[31:0]};
                    end
                end
                ACT_STR: begin
                    if (d_out == 64'd0) begin
                        do_close = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                        n_left  = d_out[31:0];
                    end
                end
                default: begin
                    n_err   = 1'b1;
                    n_phase = PH_TAG;
                end
            endcase
        end

        n_depth = r_depth;
        if (do_push) begin
            n_depth = r_depth + DW'(1);
        end else if (do_close) begin
            if (cl_found) begin
                n_depth = cl_top + DW'(1);
            end else begin
                n_depth = '0;
                n_fin   = 1'b1;
            end
        end
        m_tok.done = do_close && !cl_found;

        e_vld = i_end_of_buffer && !n_fin && !n_err;
        e_tok = '{kind: KIND_ERROR, value: CAUSE_TRUNC, level: 5'(n_depth), done: 1'b0,
                  used: n_count, last: 1'b1};
        if (e_vld) begin
            n_err   = 1'b1;
            n_phase = PH_TAG;
        end
        m_tok.last = !e_vld;
    end

    logic live;
    assign live = in_acc && !r_fin && !r_err;

    // --- queue write side
    logic [1:0] wr1, n_wr, n_rd, push_n;
    t_tok       q0, q1;
    assign wr1 = (r_wr == 2'd2) ? 2'd0 : r_wr + 2'd1;
    always_comb begin
        q0     = m_vld ? m_tok : e_tok;
        q1     = e_tok;
        push_n = live ? ({1'b0, m_vld} + {1'b0, e_vld}) : 2'd0;
        n_wr   = (push_n == 2'd0) ? r_wr : (push_n == 2'd1) ? wr1
               : ((wr1 == 2'd2) ? 2'd0 : wr1 + 2'd1);
        n_rd   = out_acc ? ((r_rd == 2'd2) ? 2'd0 : r_rd + 2'd1) : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DEPTH; i++) r_rem[i] <= '0;
            r_depth <= '0;
            r_phase <= PH_TAG;
            r_tag   <= '0;
            r_shift <= '0;
            r_left  <= '0;
            r_count <= '0;
            r_fin   <= 1'b0;
            r_err   <= 1'b0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_cnt   <= '0;
        end else begin
            if (live) begin
                for (int i = 0; i < MAX_DEPTH; i++) begin
                    if (do_push && DW'(i) == r_depth) r_rem[i] <= push_val;
                    if (do_close && cl_found && DW'(i) == cl_top)
                        r_rem[i] <= r_rem[i] - 33'd1;
                end
                r_depth <= n_depth;
                r_phase <= n_phase;
                r_tag   <= n_tag;
                r_shift <= n_shift;
                r_left  <= n_left;
                r_count <= n_count;
                r_fin   <= n_fin;
                r_err   <= n_err;
            end
            if (push_n != 2'd0) r_q[r_wr] <= q0;
            if (push_n == 2'd2) r_q[wr1]  <= q1;
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= r_cnt + push_n - {1'b0, out_acc};
        end
    end

    assign o_out_valid   = r_cnt != 2'd0;
    assign o_token_kind  = r_q[r_rd].kind;
    assign o_token_value = r_q[r_rd].value;
    assign o_nest_level  = r_q[r_rd].level;
    assign o_object_done = r_q[r_rd].done;
    assign o_bytes_used  = r_q[r_rd].used;
    assign o_last_of_run = r_q[r_rd].last;

endmodule
